// ===== hdl/bounded_double_ended_queue_defines.svh =====
// Assertion macros shared by the queue's checker.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BDEQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BDEQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bdeq_pkg.sv =====
// Shared constants, codes and types of the bounded double-ended queue.
`default_nettype none
package bdeq_pkg;

  // Sizing
  localparam int DEPTH   = 32;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VAL_W   = 32;
  localparam int FUNC_W  = 3;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 6;

  // Stream packing
  localparam int IN_DATA_W  = VAL_W;
  localparam int IN_USER_W  = FUNC_W;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 1 + STAT_W;
  localparam int OUT_PAD_W  = OUT_DATA_W - VAL_W - COUNT_W;

  // Function codes
  localparam logic [FUNC_W-1:0] FN_INIT       = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DUMP_FWD   = 3'd5;
  localparam logic [FUNC_W-1:0] FN_DUMP_REV   = 3'd6;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SINGLE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

  // Element store access from the sequencer
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage
`default_nettype wire

// ===== hdl/bdeq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module bdeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hdl/bdeq_ctrl.sv =====
// Queue sequencer: ring pointers, count, store accesses and result register.
`default_nettype none
module bdeq_ctrl
  import bdeq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [FUNC_W-1:0] in_func,
  input  wire logic [VAL_W-1:0]  in_value,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [VAL_W-1:0]  out_item,
  output logic                   out_has,
  output logic                   out_last,
  output logic      [STAT_W-1:0] out_stat,
  output logic      [COUNT_W-1:0] out_count,
  output mem_req_t               mem_req,
  input  wire logic [VAL_W-1:0]  mem_rdata
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_LD   = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   front_r, front_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   left_r, left_nxt;
  logic               rev_r, rev_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]   out_item_r, out_item_nxt;
  logic               out_has_r, out_has_nxt;
  logic               out_last_r, out_last_nxt;
  logic [STAT_W-1:0]  out_stat_r, out_stat_nxt;
  logic [CNT_W-1:0]   out_cnt_r, out_cnt_nxt;
  logic               out_free;
  logic               is_last;

  // ring step forward
  function automatic logic [IDX_W-1:0] inc_wrap(input logic [IDX_W-1:0] p);
    inc_wrap = (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // ring step backward
  function automatic logic [IDX_W-1:0] dec_wrap(input logic [IDX_W-1:0] p);
    dec_wrap = (p == '0) ? IDX_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  // (base + off) mod DEPTH, both below DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W + 1)'(DEPTH)) begin
      sum = sum - (IDX_W + 1)'(DEPTH);
    end
    ring_add = sum[IDX_W-1:0];
  endfunction

  assign out_free = !out_valid_r || out_tready;
  assign is_last  = (left_r == CNT_W'(1));

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    left_nxt      = left_r;
    rev_nxt       = rev_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_item_nxt  = out_item_r;
    out_has_nxt   = out_has_r;
    out_last_nxt  = out_last_r;
    out_stat_nxt  = out_stat_r;
    out_cnt_nxt   = out_cnt_r;
    mem_req       = '0;
    in_tready     = 1'b0;

    case (state_r)
      // take one operation when the result register can hold its answer
      ST_IDLE: begin
        in_tready = out_free;
        if (in_tvalid && out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '0;
          out_has_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          out_stat_nxt  = STAT_DONE;
          case (in_func)
            FN_INIT: begin
              front_nxt     = '0;
              cnt_nxt       = CNT_W'(1);
              mem_req.we    = 1'b1;
              mem_req.waddr = '0;
              mem_req.wdata = in_value;
            end
            FN_PUSH_BACK: begin
              if (cnt_r >= CNT_W'(DEPTH)) begin
                out_stat_nxt = STAT_FULL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ring_add(front_r, cnt_r[IDX_W-1:0]);
                mem_req.wdata = in_value;
                cnt_nxt       = cnt_r + 1'b1;
              end
            end
            FN_PUSH_FRONT: begin
              if (cnt_r >= CNT_W'(DEPTH)) begin
                out_stat_nxt = STAT_FULL;
              end else begin
                front_nxt     = dec_wrap(front_r);
                mem_req.we    = 1'b1;
                mem_req.waddr = dec_wrap(front_r);
                mem_req.wdata = in_value;
                cnt_nxt       = cnt_r + 1'b1;
              end
            end
            FN_POP_BACK: begin
              if (cnt_r <= CNT_W'(1)) begin
                out_stat_nxt = STAT_SINGLE;
              end else begin
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            FN_POP_FRONT: begin
              if (cnt_r <= CNT_W'(1)) begin
                out_stat_nxt = STAT_SINGLE;
              end else begin
                front_nxt = inc_wrap(front_r);
                cnt_nxt   = cnt_r - 1'b1;
              end
            end
            FN_DUMP_FWD, FN_DUMP_REV: begin
              // empty queue answers with the single plain beat set above
              if (cnt_r != '0) begin
                out_valid_nxt = 1'b0;
                rev_nxt       = (in_func == FN_DUMP_REV);
                ptr_nxt       = (in_func == FN_DUMP_REV) ?
                                ring_add(front_r, IDX_W'(cnt_r - 1'b1)) : front_r;
                left_nxt      = cnt_r;
                state_nxt     = ST_RD;
              end
            end
            default: begin
            end
          endcase
          out_cnt_nxt = cnt_nxt;
        end
      end

      // prime the read port with the first element
      ST_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = ptr_r;
        ptr_nxt       = rev_r ? dec_wrap(ptr_r) : inc_wrap(ptr_r);
        state_nxt     = ST_LD;
      end

      // move read data to the result register, fetch the next element
      ST_LD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = mem_rdata;
          out_has_nxt   = 1'b1;
          out_last_nxt  = is_last;
          out_stat_nxt  = STAT_DONE;
          out_cnt_nxt   = cnt_r;
          left_nxt      = left_r - 1'b1;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = ptr_r;
            ptr_nxt       = rev_r ? dec_wrap(ptr_r) : inc_wrap(ptr_r);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // dump walk and result payload
  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    left_r     <= left_nxt;
    rev_r      <= rev_nxt;
    out_item_r <= out_item_nxt;
    out_has_r  <= out_has_nxt;
    out_last_r <= out_last_nxt;
    out_stat_r <= out_stat_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_item   = out_item_r;
  assign out_has    = out_has_r;
  assign out_last   = out_last_r;
  assign out_stat   = out_stat_r;
  assign out_count  = COUNT_W'(out_cnt_r);

endmodule
`default_nettype wire

// ===== hdl/bounded_double_ended_queue.sv =====
// Top level of the bounded double-ended queue.
`default_nettype none
// Bounded double-ended queue of signed 32-bit values, kept as a ring in a
// single RAM with a registered read port. Each beat on the input carries one
// operation. Init, pushes, pops and unused codes each give one result beat
// from the output register, so one such operation can be taken per cycle
// while the output side keeps up. A dump of N elements holds the input off
// while it primes the RAM read port and then gives one element beat per
// cycle, paced by the single read port and by out_tready. Empty dumps give
// one beat with no value. The store has no reset; entries are only read
// after being written, so no clearing pass runs after reset.
module bounded_double_ended_queue
  import bdeq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] value
  input  wire logic [IN_USER_W-1:0]  in_tuser,   // [2:0] func
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // [31:0] item_value, [37:32] count, pad
  output logic      [OUT_USER_W-1:0] out_tuser,  // [0] has_value, [2:1] status
  output logic                       out_tlast   // last
);

  mem_req_t           mem_req;
  logic [VAL_W-1:0]   mem_rdata;
  logic [VAL_W-1:0]   res_item;
  logic               res_has;
  logic [STAT_W-1:0]  res_stat;
  logic [COUNT_W-1:0] res_count;

  bdeq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser[FUNC_W-1:0]),
    .in_value   (in_tdata[VAL_W-1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_item   (res_item),
    .out_has    (res_has),
    .out_last   (out_tlast),
    .out_stat   (res_stat),
    .out_count  (res_count),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata)
  );

  bdeq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // result packing
  assign out_tdata = {{OUT_PAD_W{1'b0}}, res_count, res_item};
  assign out_tuser = {res_stat, res_has};

endmodule
`default_nettype wire

// ===== hdl/bdeq_checker.sv =====
// Port-level checks of the queue, bound to the top level.
`default_nettype none
`include "bounded_double_ended_queue_defines.svh"
module bdeq_checker
  import bdeq_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [IN_DATA_W-1:0]  in_tdata,
  input wire logic [IN_USER_W-1:0]  in_tuser,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [OUT_USER_W-1:0] out_tuser,
  input wire logic                  out_tlast
);

  logic                                  in_stall;
  logic                                  out_stall;
  logic                                  has_val;
  logic                                  out_mid_dump;
  logic [VAL_W-1:0]                      out_item;
  logic [IN_DATA_W+IN_USER_W-1:0]        in_beat;
  logic [OUT_DATA_W+OUT_USER_W:0]        out_beat;

  assign in_stall     = in_tvalid && !in_tready;
  assign out_stall    = out_tvalid && !out_tready;
  assign has_val      = out_tuser[0];
  assign out_mid_dump = out_tvalid && has_val && !out_tlast;
  assign out_item     = out_tdata[VAL_W-1:0];
  assign in_beat      = {in_tuser, in_tdata};
  assign out_beat     = {out_tlast, out_tuser, out_tdata};

  // stalled result beat holds
  `BDEQ_ASSERT_NXT(a_out_hold, out_stall, out_tvalid && $stable(out_beat), "stalled result changed")

  // stalled input beat holds
  `BDEQ_ASSERT_NXT(a_in_hold, in_stall, in_tvalid && $stable(in_beat), "stalled input changed")

  // beats without a value carry a zero item
  `BDEQ_ASSERT_IMP(a_item_zero, out_tvalid && !has_val, out_item == '0, "stray item value")

  // a dump streams without gaps once its first element is out
  `BDEQ_ASSERT_NXT(a_dump_stream, out_mid_dump && out_tready, out_tvalid && has_val, "gap inside a dump")

  // no operation is taken while a dump is still running
  `BDEQ_ASSERT_IMP(a_dump_block, out_mid_dump, !in_tready, "input taken during a dump")

endmodule

bind bounded_double_ended_queue bdeq_checker u_bdeq_checker (.*);
`default_nettype wire
